// ----- rtl/vspfc_pkg.sv -----
// Shared types, codes and the CRC helper for the video packet frame capture.
// Depends on nothing; imported by vspfc_rx and video_spi_packet_frame_capture.
`default_nettype none

package vspfc_pkg;

  // Field widths fixed by the interface
  localparam int COL_W = 7;

  // CRC16-CCITT generator polynomial
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Request types on the input channel
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Result status codes
  localparam logic [2:0] PS_STORED     = 3'd0;
  localparam logic [2:0] PS_DISCARD    = 3'd1;
  localparam logic [2:0] PS_CRC_ERR    = 3'd2;
  localparam logic [2:0] PS_LINE_RANGE = 3'd3;
  localparam logic [2:0] PS_READ       = 3'd4;

  // Low nibble of the ID byte that marks a discard packet
  localparam logic [3:0] ID_DISCARD = 4'hF;

  // Reset value of the packet limit register
  localparam logic [15:0] MAX_PKT_RESET = 16'd1000;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_JUDGE,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_EMIT,
    ST_COPY,
    ST_DRAIN
  } st_t;

  // Packet parser status toward the sequencer
  typedef struct packed {
    logic        last;
    logic [7:0]  id;
    logic [7:0]  line;
    logic [15:0] crc;
    logic [15:0] rcrc;
  } rx_info_t;

  // Staging row write port
  typedef struct packed {
    logic             we;
    logic [COL_W-1:0] idx;
    logic [15:0]      data;
  } stg_wr_t;

  // Advance the CRC by one byte, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/vspfc_rx.sv -----
// Packet byte parser: byte position, running CRC, header capture, staging writes.
// Depends on vspfc_pkg.
`default_nettype none

module vspfc_rx #(
  parameter int WIDTH = 80
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 byte_en,
  input  wire  [7:0]          rx_byte,
  input  wire                 packet_start,
  output vspfc_pkg::rx_info_t info,
  output vspfc_pkg::stg_wr_t  stg_wr
);
  import vspfc_pkg::*;

  localparam int PKT_LEN = 4 + 2 * WIDTH;

  logic [7:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  line_r, line_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;
  logic [7:0]  hi_r, hi_nxt;

  logic        active;
  logic        last_byte;
  logic [7:0]  pos_cur;
  logic [7:0]  feed;
  logic [7:0]  off;
  logic        pix_byte;

  // Decode the position of the incoming byte
  always_comb begin
    active    = byte_en && (packet_start || (pos_r != 8'd0));
    pos_cur   = packet_start ? 8'd0 : pos_r;
    feed      = ((pos_cur == 8'd2) || (pos_cur == 8'd3)) ? 8'h00 : rx_byte;
    last_byte = ({1'b0, pos_cur} + 9'd1) == 9'(PKT_LEN);
    off       = pos_cur - 8'd4;
    pix_byte  = pos_cur >= 8'd4;
  end

  // Advance position and CRC, capture header fields
  always_comb begin
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    id_nxt   = id_r;
    line_nxt = line_r;
    rcrc_nxt = rcrc_r;
    hi_nxt   = hi_r;
    if (active) begin
      pos_nxt = last_byte ? 8'd0 : pos_cur + 8'd1;
      crc_nxt = crc_feed(packet_start ? 16'h0000 : crc_r, feed);
      case (pos_cur)
        8'd0:    id_nxt = rx_byte;
        8'd1:    line_nxt = rx_byte;
        8'd2:    rcrc_nxt = {rx_byte, 8'h00};
        8'd3:    rcrc_nxt = {rcrc_r[15:8], rx_byte};
        default: if (!off[0]) hi_nxt = rx_byte;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 8'd0;
      crc_r  <= 16'h0000;
      id_r   <= 8'd0;
      line_r <= 8'd0;
      rcrc_r <= 16'h0000;
    end else begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      id_r   <= id_nxt;
      line_r <= line_nxt;
      rcrc_r <= rcrc_nxt;
    end
  end

  // High pixel byte waits here for its low byte
  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
  end

  // Whole pixel goes to staging on its low byte
  always_comb begin
    stg_wr.we   = active && pix_byte && off[0];
    stg_wr.idx  = off[7:1];
    stg_wr.data = {hi_r, rx_byte};
    info.last   = active && last_byte;
    info.id     = id_r;
    info.line   = line_r;
    info.crc    = crc_r;
    info.rcrc   = rcrc_r;
  end

endmodule

`default_nettype wire

// ----- rtl/video_spi_packet_frame_capture.sv -----
// Video-over-SPI packet receiver with CRC check and frame store capture.
// Depends on vspfc_pkg and vspfc_rx.
//
// Packet bytes are taken one per cycle while the sequencer is idle. On the
// last byte of a packet the block judges it and then presents the result,
// and a good packet in range is then copied from the staging row memory
// into the frame store one pixel per cycle over the frame store's single
// write port; the input stays stalled until the copy is done. A pixel read
// registers the address, reads the memory into a register and loads the result. The
// frame store reads as zero after reset through one valid bit per row, so no
// clearing pass is needed. A result waiting on a stalled output blocks
// further packet bytes and pixel reads.
`default_nettype none

module video_spi_packet_frame_capture #(
  parameter int HEIGHT = 60,
  parameter int WIDTH  = 80
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [15:0] cfg_wr_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_req_type,
  input  wire  [7:0]  in_rx_byte,
  input  wire         in_packet_start,
  input  wire  [5:0]  in_read_row,
  input  wire  [6:0]  in_read_col,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  out_packet_status,
  output logic [7:0]  out_line_number,
  output logic [15:0] out_pixel_value,
  output logic        out_frame_done,
  output logic        out_capture_timeout
);
  import vspfc_pkg::*;

  localparam int DEPTH = HEIGHT * WIDTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int ROW_W = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;

  st_t state_r, state_nxt;

  rx_info_t info;
  stg_wr_t  stg_wr;

  logic in_acc;
  logic byte_en;
  logic rd_en;

  logic [15:0] max_pkt_r;
  logic [15:0] pkt_cnt_r, pkt_cnt_nxt;
  logic [HEIGHT-1:0] row_vld_r, row_vld_nxt;
  logic        commit_r, commit_nxt;
  logic [AW-1:0] base_r, base_nxt;

  // Pending result
  logic [2:0]  res_status_r, res_status_nxt;
  logic [7:0]  res_line_r, res_line_nxt;
  logic [15:0] res_pix_r, res_pix_nxt;
  logic        res_done_r, res_done_nxt;
  logic        res_tmo_r, res_tmo_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_load;
  logic [2:0]  out_status_r;
  logic [7:0]  out_line_r;
  logic [15:0] out_pix_r;
  logic        out_done_r;
  logic        out_tmo_r;

  // Pixel read path
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [7:0]    rd_row8;
  logic          rd_in_rng;
  logic [15:0]   rd_lin;
  logic [15:0]   frame_q_r;

  // Copy sweep
  logic [CW-1:0] cp_idx_r, cp_idx_nxt;
  logic [CW-1:0] cp_wa_r;
  logic          cp_v_r;
  logic [15:0]   stg_q_r;

  // Judge terms
  logic        discard;
  logic        crc_bad;
  logic        good;
  logic        line_in_rng;
  logic [16:0] cnt_inc;
  logic        tmo;
  logic        done;
  logic [15:0] base_lin;

  logic [15:0] stg_mem   [WIDTH];
  logic [15:0] frame_mem [DEPTH];

  vspfc_rx #(
    .WIDTH (WIDTH)
  ) u_rx (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_en      (byte_en),
    .rx_byte      (in_rx_byte),
    .packet_start (in_packet_start),
    .info         (info),
    .stg_wr       (stg_wr)
  );

  // Accept only while the sequencer is idle
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign byte_en  = in_acc && (in_req_type == REQ_BYTE);
  assign rd_en    = in_acc && (in_req_type == REQ_READ);

  // Read address and range check
  always_comb begin
    rd_row8   = {2'b00, in_read_row};
    rd_in_rng = ({3'b000, in_read_row} < 9'(HEIGHT)) &&
                ({1'b0, in_read_col} < 8'(WIDTH));
    rd_lin    = 16'(rd_row8) * 16'(WIDTH) + 16'(in_read_col);
  end

  // Judge the finished packet
  always_comb begin
    discard     = (info.id[3:0] == ID_DISCARD);
    crc_bad     = (info.crc != info.rcrc);
    good        = !discard && !crc_bad;
    line_in_rng = {1'b0, info.line} < 9'(HEIGHT);
    cnt_inc     = {1'b0, pkt_cnt_r} + 17'd1;
    tmo         = cnt_inc >= {1'b0, max_pkt_r};
    done        = !tmo && good && ({1'b0, info.line} == 9'(HEIGHT - 1));
    base_lin    = 16'(info.line) * 16'(WIDTH);
  end

  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // Sequencer next state and datapath updates
  always_comb begin
    state_nxt      = state_r;
    pkt_cnt_nxt    = pkt_cnt_r;
    row_vld_nxt    = row_vld_r;
    commit_nxt     = commit_r;
    base_nxt       = base_r;
    res_status_nxt = res_status_r;
    res_line_nxt   = res_line_r;
    res_pix_nxt    = res_pix_r;
    res_done_nxt   = res_done_r;
    res_tmo_nxt    = res_tmo_r;
    rd_addr_nxt    = rd_addr_r;
    rd_ok_nxt      = rd_ok_r;
    cp_idx_nxt     = cp_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (rd_en) begin
          rd_ok_nxt   = rd_in_rng && row_vld_r[rd_row8[ROW_W-1:0]];
          rd_addr_nxt = rd_in_rng ? rd_lin[AW-1:0] : '0;
          state_nxt   = ST_RD_ADDR;
        end else if (info.last) begin
          state_nxt = ST_JUDGE;
        end
      end
      ST_JUDGE: begin
        if (discard) begin
          res_status_nxt = PS_DISCARD;
        end else if (crc_bad) begin
          res_status_nxt = PS_CRC_ERR;
        end else if (line_in_rng) begin
          res_status_nxt = PS_STORED;
        end else begin
          res_status_nxt = PS_LINE_RANGE;
        end
        res_line_nxt = info.line;
        res_pix_nxt  = 16'h0000;
        res_done_nxt = done;
        res_tmo_nxt  = tmo;
        pkt_cnt_nxt  = (tmo || done) ? 16'h0000 : cnt_inc[15:0];
        commit_nxt   = good && line_in_rng;
        base_nxt     = base_lin[AW-1:0];
        if (good && line_in_rng) begin
          row_vld_nxt[info.line[ROW_W-1:0]] = 1'b1;
        end
        state_nxt = ST_EMIT;
      end
      ST_RD_ADDR: begin
        state_nxt = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        res_status_nxt = PS_READ;
        res_line_nxt   = 8'd0;
        res_pix_nxt    = rd_ok_r ? frame_q_r : 16'h0000;
        res_done_nxt   = 1'b0;
        res_tmo_nxt    = 1'b0;
        commit_nxt     = 1'b0;
        state_nxt      = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          cp_idx_nxt = '0;
          state_nxt  = commit_r ? ST_COPY : ST_IDLE;
        end
      end
      ST_COPY: begin
        if (cp_idx_r == CW'(WIDTH - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          cp_idx_nxt = cp_idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the output until the transaction completes
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_pkt_r   <= MAX_PKT_RESET;
      pkt_cnt_r   <= 16'h0000;
      row_vld_r   <= '0;
      commit_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cp_v_r      <= 1'b0;
      cp_idx_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      pkt_cnt_r   <= pkt_cnt_nxt;
      row_vld_r   <= row_vld_nxt;
      commit_r    <= commit_nxt;
      out_valid_r <= out_valid_nxt;
      cp_v_r      <= (state_r == ST_COPY);
      cp_idx_r    <= cp_idx_nxt;
      if (cfg_wr_en) begin
        max_pkt_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    res_status_r <= res_status_nxt;
    res_line_r   <= res_line_nxt;
    res_pix_r    <= res_pix_nxt;
    res_done_r   <= res_done_nxt;
    res_tmo_r    <= res_tmo_nxt;
    rd_addr_r    <= rd_addr_nxt;
    rd_ok_r      <= rd_ok_nxt;
    cp_wa_r      <= cp_idx_r;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_line_r   <= res_line_r;
      out_pix_r    <= res_pix_r;
      out_done_r   <= res_done_r;
      out_tmo_r    <= res_tmo_r;
    end
  end

  // Staging row memory: written by the parser, read by the copy sweep
  always_ff @(posedge clk) begin
    if (stg_wr.we) begin
      stg_mem[stg_wr.idx[CW-1:0]] <= stg_wr.data;
    end
    stg_q_r <= stg_mem[cp_idx_r];
  end

  // Frame store: written by the copy sweep, read for pixel requests
  always_ff @(posedge clk) begin
    if (cp_v_r) begin
      frame_mem[base_r + AW'(cp_wa_r)] <= stg_q_r;
    end
    frame_q_r <= frame_mem[rd_addr_r];
  end

  assign out_valid           = out_valid_r;
  assign out_packet_status   = out_status_r;
  assign out_line_number     = out_line_r;
  assign out_pixel_value     = out_pix_r;
  assign out_frame_done      = out_done_r;
  assign out_capture_timeout = out_tmo_r;

endmodule

`default_nettype wire
